// ===== hdl/dense_layer_forward_mac_assert.svh =====
// assertion macros for the dense layer forward block
// expects signals named clk and rst in the including module
`ifndef DENSE_LAYER_FORWARD_MAC_ASSERT_SVH
`define DENSE_LAYER_FORWARD_MAC_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define DLFM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dlfm: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define DLFM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dlfm: next-cycle check failed");

`endif

// ===== hdl/dlfm_pkg.sv =====
// shared constants, codes and types for the dense layer forward block
// no dependencies
`default_nettype none

package dlfm_pkg;

  // sizing
  localparam int MAX_INPUTS  = 256;
  localparam int MAX_OUTPUTS = 64;
  localparam int STORE_DEPTH = (MAX_INPUTS + 1) * MAX_OUTPUTS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int ROW_W       = 9;
  localparam int COL_W       = 6;
  localparam int ELEM_W      = $clog2(MAX_INPUTS);
  localparam int IC_W        = 9;
  localparam int DATA_W      = 16;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int ACC_W       = 48;
  localparam int SHIFT_W     = 5;
  localparam int SCALE_W     = 17;
  localparam int SCALE_FRAC  = 16;
  localparam int CFG_W       = 17;
  localparam int CFG_IDX_W   = 3;

  // scaling applies only for keep factors at or below this
  localparam logic [SCALE_W-1:0] KEEP_LIMIT = SCALE_W'(64880);

  // request codes
  localparam logic OP_WEIGHT = 1'b0;
  localparam logic OP_PUSH   = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_COUNT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NEURON_COUNT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_ELEM    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_RESULT_SHIFT = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_SCALE   = CFG_IDX_W'(4);

  // control that travels with one accumulator into the output stage
  typedef struct packed {
    logic             valid;
    logic [COL_W-1:0] index;
    logic             last;
  } emit_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/dlfm_out_stage.sv =====
// output stage: shift, saturate and dropout scaling of one accumulator per cycle
// depends on dlfm_pkg
`default_nettype none

module dlfm_out_stage (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire dlfm_pkg::emit_ctl_t            ctl,
  input  wire logic signed [dlfm_pkg::ACC_W-1:0]   acc,
  input  wire logic [dlfm_pkg::SHIFT_W-1:0]   result_shift,
  input  wire logic [dlfm_pkg::SCALE_W-1:0]   keep_scale,
  output logic                                out_valid,
  output logic signed [dlfm_pkg::DATA_W-1:0]  out_value,
  output logic [dlfm_pkg::COL_W-1:0]          out_index,
  output logic                                out_last
);
  import dlfm_pkg::*;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);
  localparam int RND_W = PROD_W + 3;
  localparam logic signed [RND_W-1:0] ROUND = RND_W'(1) <<< (SCALE_FRAC - 1);

  logic signed [ACC_W-1:0]      shifted;
  logic signed [DATA_W-1:0]     sat_comb;
  logic signed [DATA_W-1:0]     sat_a;
  emit_ctl_t                    ctl_a;
  logic                         scale_a;
  logic signed [PROD_W+1:0]     prod_b;
  logic signed [DATA_W-1:0]     sat_b;
  emit_ctl_t                    ctl_b;
  logic                         scale_b;
  logic signed [RND_W-1:0]      rounded;

  // floor shift and clamp to 16 bits
  always_comb begin
    shifted = acc >>> result_shift;
    if (shifted > SAT_HI) begin
      sat_comb = DATA_W'(32767);
    end else if (shifted < SAT_LO) begin
      sat_comb = -DATA_W'(32768);
    end else begin
      sat_comb = shifted[DATA_W-1:0];
    end
  end

  // stage a: saturated value and scale decision
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a <= '0;
    end else begin
      ctl_a <= ctl;
    end
    sat_a   <= sat_comb;
    scale_a <= !ctl.last && (keep_scale <= KEEP_LIMIT);
  end

  // stage b: multiply by the keep factor
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_b <= '0;
    end else begin
      ctl_b <= ctl_a;
    end
    prod_b  <= sat_a * $signed({1'b0, keep_scale});
    sat_b   <= sat_a;
    scale_b <= scale_a;
  end

  // round and drop the fraction
  assign rounded = RND_W'(prod_b) + ROUND;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= ctl_b.valid;
    end
    out_index <= ctl_b.index;
    out_last  <= ctl_b.last;
    out_value <= scale_b ? rounded[SCALE_FRAC +: DATA_W] : sat_b;
  end

endmodule

`default_nettype wire

// ===== hdl/dense_layer_forward_mac.sv =====
// dense layer forward: per element a read-multiply-accumulate-write pass over idx 0..n
// and a drain, n = neuron_count; a sample's last element adds a bias pass with its own
// drain, then an emission and a flush; results one per cycle, registered through e1_ctl
// and output stages a, b and the output register; a weight write makes no busy time.
// the accumulator memory port (one entry per cycle) sets the rate; results cannot stall.
// reset clears control, registers go to defaults, accumulators read as zero; weights stay
`default_nettype none

module dense_layer_forward_mac (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             operation,
  input  wire logic [dlfm_pkg::ROW_W-1:0]       weight_row,
  input  wire logic [dlfm_pkg::COL_W-1:0]       weight_col,
  input  wire logic signed [dlfm_pkg::DATA_W-1:0] weight_value,
  input  wire logic signed [dlfm_pkg::DATA_W-1:0] sample_value,
  input  wire logic                             sample_last,
  input  wire logic                             cfg_we,
  input  wire logic [dlfm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dlfm_pkg::CFG_W-1:0]       cfg_data,
  output logic                                  out_valid,
  output logic signed [dlfm_pkg::DATA_W-1:0]    out_value,
  output logic [dlfm_pkg::COL_W-1:0]            out_index,
  output logic                                  out_last
);
  import dlfm_pkg::*;

  `include "dense_layer_forward_mac_assert.svh"

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MAC   = 5'b00010,
    S_DRAIN = 5'b00100,
    S_EMIT  = 5'b01000,
    S_FLUSH = 5'b10000
  } state_t;

  localparam logic [ROW_W-1:0] BIAS_ROW  = ROW_W'(MAX_INPUTS);
  localparam logic [COL_W-1:0] MAX_NEUR  = COL_W'(MAX_OUTPUTS - 1);

  // configuration registers
  logic [IC_W-1:0]          input_count;
  logic [COL_W-1:0]         neuron_count;
  logic signed [DATA_W-1:0] bias_elem;
  logic [SHIFT_W-1:0]       result_shift;
  logic [SCALE_W-1:0]       keep_scale;

  // control
  state_t                   state;
  logic [COL_W-1:0]         idx;
  logic                     drain_cnt;
  logic [1:0]               flush_cnt;
  logic [ELEM_W-1:0]        elem_cnt;
  logic [ROW_W-1:0]         cur_row;
  logic signed [DATA_W-1:0] cur_x;
  logic                     sample_done;
  logic                     bias_pass;

  // request decode
  logic                     accept;
  logic [IC_W-1:0]          count;
  logic [ELEM_W-1:0]        elem_eff;
  logic [IC_W:0]            elem_next_w;
  logic                     push_done;
  logic [COL_W-1:0]         n_used;
  logic                     last_idx;

  // memories and pipeline
  logic signed [DATA_W-1:0] wmem [STORE_DEPTH];
  logic signed [ACC_W-1:0]  amem [MAX_OUTPUTS];
  logic [MAX_OUTPUTS-1:0]   acc_valid;
  logic [ADDR_W-1:0]        w_wr_addr;
  logic [ADDR_W-1:0]        w_rd_addr;
  logic signed [DATA_W-1:0] w_rd;
  logic signed [ACC_W-1:0]  acc_rd;
  logic                     acc_rd_ok;
  logic                     s1_valid;
  logic [COL_W-1:0]         s1_idx;
  logic                     s2_valid;
  logic [COL_W-1:0]         s2_idx;
  logic signed [PROD_W-1:0] s2_prod;
  logic signed [ACC_W-1:0]  s2_acc;
  logic signed [ACC_W-1:0]  wb_sum;
  emit_ctl_t                e1_ctl;
  logic signed [ACC_W-1:0]  e1_acc;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign n_used = (neuron_count > MAX_NEUR) ? MAX_NEUR : neuron_count;
  assign last_idx = (idx == n_used);

  // effective element position and end of sample
  always_comb begin
    if (input_count == '0) begin
      count = IC_W'(1);
    end else if (input_count > IC_W'(MAX_INPUTS)) begin
      count = IC_W'(MAX_INPUTS);
    end else begin
      count = input_count;
    end
    if (IC_W'(elem_cnt) >= count) begin
      elem_eff = ELEM_W'(count - IC_W'(1));
    end else begin
      elem_eff = elem_cnt;
    end
    elem_next_w = (IC_W+1)'(elem_eff) + (IC_W+1)'(1);
    push_done   = sample_last || (elem_next_w >= (IC_W+1)'(count));
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      input_count  <= IC_W'(256);
      neuron_count <= COL_W'(63);
      bias_elem    <= DATA_W'(4096);
      result_shift <= SHIFT_W'(12);
      keep_scale   <= SCALE_W'(65536);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INPUT_COUNT:  input_count  <= cfg_data[IC_W-1:0];
        REG_NEURON_COUNT: neuron_count <= cfg_data[COL_W-1:0];
        REG_BIAS_ELEM:    bias_elem    <= cfg_data[DATA_W-1:0];
        REG_RESULT_SHIFT: result_shift <= cfg_data[SHIFT_W-1:0];
        REG_KEEP_SCALE:   keep_scale   <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      idx         <= '0;
      drain_cnt   <= 1'b0;
      flush_cnt   <= '0;
      elem_cnt    <= '0;
      sample_done <= 1'b0;
      bias_pass   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && operation == OP_PUSH) begin
            state       <= S_MAC;
            idx         <= '0;
            sample_done <= push_done;
            bias_pass   <= 1'b0;
            elem_cnt    <= push_done ? '0 : elem_next_w[ELEM_W-1:0];
          end
        end
        S_MAC: begin
          if (last_idx) begin
            state     <= S_DRAIN;
            idx       <= '0;
            drain_cnt <= 1'b0;
          end else begin
            idx <= idx + COL_W'(1);
          end
        end
        S_DRAIN: begin
          drain_cnt <= 1'b1;
          if (drain_cnt) begin
            if (bias_pass) begin
              state <= S_EMIT;
            end else if (sample_done) begin
              state     <= S_MAC;
              bias_pass <= 1'b1;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_EMIT: begin
          if (last_idx) begin
            state     <= S_FLUSH;
            idx       <= '0;
            flush_cnt <= '0;
          end else begin
            idx <= idx + COL_W'(1);
          end
        end
        S_FLUSH: begin
          flush_cnt <= flush_cnt + 2'd1;
          if (flush_cnt == 2'd2) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // operand of the current pass
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept && operation == OP_PUSH) begin
      cur_row <= ROW_W'(elem_eff);
      cur_x   <= sample_value;
    end else if (state == S_DRAIN && drain_cnt && !bias_pass && sample_done) begin
      cur_row <= BIAS_ROW;
      cur_x   <= bias_elem;
    end
  end

  // weight store: written by weight requests, read during a pass
  assign w_wr_addr = ADDR_W'(weight_row * MAX_OUTPUTS + weight_col);
  assign w_rd_addr = ADDR_W'(cur_row * MAX_OUTPUTS + idx);

  always_ff @(posedge clk) begin
    if (accept && operation == OP_WEIGHT && weight_row <= BIAS_ROW) begin
      wmem[w_wr_addr] <= weight_value;
    end
    w_rd <= wmem[w_rd_addr];
  end

  // accumulator memory: read at idx, written back from stage s2 with the product added
  assign wb_sum = s2_acc + ACC_W'(s2_prod);

  always_ff @(posedge clk) begin
    acc_rd <= amem[idx];
    if (s2_valid) begin
      amem[s2_idx] <= wb_sum;
    end
  end

  // valid flags stand in for clearing the accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= '0;
      acc_rd_ok <= 1'b0;
    end else begin
      acc_rd_ok <= acc_valid[idx];
      if (state == S_EMIT && last_idx) begin
        acc_valid <= '0;
      end else if (s2_valid) begin
        acc_valid[s2_idx] <= 1'b1;
      end
    end
  end

  // multiply-accumulate pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= (state == S_MAC);
      s2_valid <= s1_valid;
    end
    s1_idx  <= idx;
    s2_idx  <= s1_idx;
    s2_prod <= w_rd * cur_x;
    s2_acc  <= acc_rd_ok ? acc_rd : '0;
  end

  // emission read side
  always_ff @(posedge clk) begin
    if (rst) begin
      e1_ctl <= '0;
    end else begin
      e1_ctl.valid <= (state == S_EMIT);
      e1_ctl.index <= idx;
      e1_ctl.last  <= last_idx;
    end
  end

  assign e1_acc = acc_rd_ok ? acc_rd : '0;

  dlfm_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .ctl          (e1_ctl),
    .acc          (e1_acc),
    .result_shift (result_shift),
    .keep_scale   (keep_scale),
    .out_valid    (out_valid),
    .out_value    (out_value),
    .out_index    (out_index),
    .out_last     (out_last)
  );

  // checks
  `DLFM_ASSERT_NEXT(a_push_goes_busy, accept && operation == OP_PUSH, busy)
  `DLFM_ASSERT_NEXT(a_weight_no_busy, accept && operation == OP_WEIGHT, !busy)
  `DLFM_ASSERT_NOW(a_wb_in_range, s2_valid, s2_idx <= n_used)
  `DLFM_ASSERT_NEXT(a_last_ends_burst, out_valid && out_last, !out_valid)
  `DLFM_ASSERT_NOW(a_no_mac_while_emit, s2_valid, !e1_ctl.valid)

endmodule

`default_nettype wire
